// ----- hdl/tprle_pkg.sv -----
// ----------------------------------------------------------------------------
// tprle_pkg
// shared types and constants for the two-plane run-length decoder
// ----------------------------------------------------------------------------
package tprle_pkg;

  // decoder phase, one per kind of byte expected next
  typedef enum logic [2:0] {
    PH_WIDTH   = 3'd0,
    PH_HDR_HI  = 3'd1,
    PH_HDR_LO  = 3'd2,
    PH_FILL    = 3'd3,
    PH_LITERAL = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  localparam int unsigned COUNT_W = 15;
  localparam int unsigned START_W = 13;
  localparam int unsigned BYTE_W  = 8;

  // width byte value that selects one-byte headers
  localparam logic [BYTE_W-1:0] NARROW_WIDTH_CODE = 8'h01;

  // repeat flag and count mask of a one-byte and a two-byte header
  localparam logic [7:0]  HDR8_REPEAT   = 8'h80;
  localparam logic [7:0]  HDR8_COUNT    = 8'h7F;
  localparam logic [15:0] HDR16_REPEAT  = 16'h8000;
  localparam logic [15:0] HDR16_COUNT   = 16'h7FFF;

  // outcome of clipping a run against plane capacity
  typedef struct packed {
    logic               emit;
    logic               over;
    logic [COUNT_W-1:0] count;
  } clip_res_t;

endpackage

// ----- hdl/tprle_clip.sv -----
// ----------------------------------------------------------------------------
// tprle_clip
// clips a run to the plane capacity and advances the write position
// ----------------------------------------------------------------------------
module tprle_clip #(
  parameter int unsigned PLANE_ENTRIES = 8192
) (
  input  logic [$clog2(PLANE_ENTRIES):0]      pos,
  input  logic [tprle_pkg::COUNT_W-1:0]       count,
  output logic [$clog2(PLANE_ENTRIES):0]      pos_next,
  output tprle_pkg::clip_res_t                res
);
  import tprle_pkg::*;

  localparam int unsigned PW = $clog2(PLANE_ENTRIES) + 1;
  localparam int unsigned XW = (PW > COUNT_W) ? PW : COUNT_W;
  localparam logic [PW-1:0] CAP = PW'(PLANE_ENTRIES);

  logic [PW-1:0] avail;

  always_comb begin
    avail     = CAP - pos;
    res.emit  = 1'b0;
    res.over  = 1'b0;
    res.count = count;
    pos_next  = pos;
    if (count == '0) begin
      res.emit = 1'b0;
    end else if (pos >= CAP) begin
      // no room left at all
      res.over = 1'b1;
      pos_next = CAP;
    end else begin
      res.emit = 1'b1;
      if (XW'(count) > XW'(avail)) begin
        res.over  = 1'b1;
        res.count = COUNT_W'(avail);
      end
      pos_next = pos + PW'(res.count);
    end
  end

endmodule

// ----- hdl/two_plane_rle_decoder_core.sv -----
// ----------------------------------------------------------------------------
// two_plane_rle_decoder_core
// decodes a two-pass byte-plane run-length stream into fill requests
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                        handshake
//  in        in         in_byte                                        in_valid/in_ready
//  out       out        out_plane, out_start_pos, out_run_count,       out_valid/out_ready
//                       out_fill_value, out_last, out_overflow
//
//  one compressed byte is taken per clock while in_ready is high; the decode step is short logic from
//  the input byte and the decoder state into the result register
//  a byte gives at most one request, registered into the result register when it is taken
//  in_ready drops while the result register holds a request that the consumer
//  stalls; every byte waits then, even one that gives no request
//  synchronous active-low reset returns to the width byte of the low plane
//
module two_plane_rle_decoder_core #(
  parameter int unsigned PLANE_ENTRIES = 8192
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tprle_pkg::BYTE_W-1:0]      in_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_plane,
  output logic [tprle_pkg::START_W-1:0]     out_start_pos,
  output logic [tprle_pkg::COUNT_W-1:0]     out_run_count,
  output logic [tprle_pkg::BYTE_W-1:0]      out_fill_value,
  output logic                              out_last,
  output logic                              out_overflow
);
  import tprle_pkg::*;

  localparam int unsigned PW = $clog2(PLANE_ENTRIES) + 1;

  // decoder state
  phase_t               phase_r, phase_nxt;
  logic                 pass_r, pass_nxt;
  logic                 wide_r, wide_nxt;
  logic [7:0]           hdr_hi_r, hdr_hi_nxt;
  logic [COUNT_W-1:0]   run_left_r, run_left_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic                 ovf_r, ovf_nxt;

  // result register
  logic                 out_valid_r;
  logic                 out_plane_r, out_plane_nxt;
  logic [START_W-1:0]   out_start_pos_r, out_start_pos_nxt;
  logic [COUNT_W-1:0]   out_run_count_r, out_run_count_nxt;
  logic [BYTE_W-1:0]    out_fill_value_r, out_fill_value_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_overflow_r, out_overflow_nxt;
  logic                 res_valid;

  logic                 in_fire;
  logic [15:0]          hdr;
  logic                 hdr_repeat;
  logic [COUNT_W-1:0]   hdr_count;
  phase_t               hdr_phase;
  logic [COUNT_W-1:0]   clip_count;
  logic [PW-1:0]        clip_pos;
  clip_res_t            clip;

  // result register frees up when empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign hdr_phase = wide_r ? PH_HDR_HI : PH_HDR_LO;

  // header assembled from the high byte when two-byte headers are in use
  always_comb begin
    if (wide_r) begin
      hdr        = {hdr_hi_r, in_byte};
      hdr_repeat = (hdr & HDR16_REPEAT) != '0;
      hdr_count  = COUNT_W'(hdr & HDR16_COUNT);
    end else begin
      hdr        = {8'h00, in_byte};
      hdr_repeat = (in_byte & HDR8_REPEAT) != '0;
      hdr_count  = COUNT_W'(in_byte & HDR8_COUNT);
    end
  end

  // a literal byte is a run of one, a fill byte carries the stored count
  assign clip_count = (phase_r == PH_FILL)    ? run_left_r :
                      (phase_r == PH_LITERAL) ? COUNT_W'(1) : '0;

  tprle_clip #(
    .PLANE_ENTRIES (PLANE_ENTRIES)
  ) u_clip (
    .pos      (pos_r),
    .count    (clip_count),
    .pos_next (clip_pos),
    .res      (clip)
  );

  always_comb begin
    phase_nxt          = phase_r;
    pass_nxt           = pass_r;
    wide_nxt           = wide_r;
    hdr_hi_nxt         = hdr_hi_r;
    run_left_nxt       = run_left_r;
    pos_nxt            = pos_r;
    ovf_nxt            = ovf_r;
    res_valid          = 1'b0;
    out_plane_nxt      = pass_r;
    out_start_pos_nxt  = START_W'(pos_r);
    out_run_count_nxt  = clip.count;
    out_fill_value_nxt = in_byte;
    out_last_nxt       = 1'b0;
    out_overflow_nxt   = ovf_r;

    unique case (phase_r)
      PH_WIDTH: begin
        wide_nxt  = (in_byte != NARROW_WIDTH_CODE);
        pos_nxt   = '0;
        phase_nxt = (in_byte != NARROW_WIDTH_CODE) ? PH_HDR_HI : PH_HDR_LO;
      end
      PH_HDR_HI: begin
        hdr_hi_nxt = in_byte;
        phase_nxt  = PH_HDR_LO;
      end
      PH_HDR_LO: begin
        if (hdr == '0) begin
          // end of pass marker
          res_valid          = 1'b1;
          out_start_pos_nxt  = '0;
          out_run_count_nxt  = '0;
          out_fill_value_nxt = '0;
          out_last_nxt       = pass_r;
          pos_nxt            = '0;
          run_left_nxt       = '0;
          pass_nxt           = 1'b1;
          phase_nxt          = pass_r ? PH_DONE : PH_WIDTH;
        end else begin
          run_left_nxt = hdr_count;
          phase_nxt    = hdr_repeat ? PH_FILL : PH_LITERAL;
        end
      end
      PH_FILL: begin
        res_valid        = clip.emit;
        pos_nxt          = clip_pos;
        ovf_nxt          = ovf_r | clip.over;
        out_overflow_nxt = ovf_r | clip.over;
        run_left_nxt     = '0;
        phase_nxt        = hdr_phase;
      end
      PH_LITERAL: begin
        res_valid        = clip.emit;
        pos_nxt          = clip_pos;
        ovf_nxt          = ovf_r | clip.over;
        out_overflow_nxt = ovf_r | clip.over;
        if (run_left_r != '0) begin
          run_left_nxt = run_left_r - COUNT_W'(1);
        end
        if (run_left_r <= COUNT_W'(1)) begin
          phase_nxt = hdr_phase;
        end
      end
      PH_DONE: begin
        // trailing bytes are dropped until reset
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // decoder state, advanced once per taken byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WIDTH;
      pass_r     <= 1'b0;
      wide_r     <= 1'b0;
      hdr_hi_r   <= '0;
      run_left_r <= '0;
      pos_r      <= '0;
      ovf_r      <= 1'b0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      pass_r     <= pass_nxt;
      wide_r     <= wide_nxt;
      hdr_hi_r   <= hdr_hi_nxt;
      run_left_r <= run_left_nxt;
      pos_r      <= pos_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // result valid: set by a byte that makes a request, cleared once drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded only with a new request
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_plane_r      <= out_plane_nxt;
      out_start_pos_r  <= out_start_pos_nxt;
      out_run_count_r  <= out_run_count_nxt;
      out_fill_value_r <= out_fill_value_nxt;
      out_last_r       <= out_last_nxt;
      out_overflow_r   <= out_overflow_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_plane      = out_plane_r;
  assign out_start_pos  = out_start_pos_r;
  assign out_run_count  = out_run_count_r;
  assign out_fill_value = out_fill_value_r;
  assign out_last       = out_last_r;
  assign out_overflow   = out_overflow_r;

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for two_plane_rle_decoder_core: one compressed stream,
// a narrow low-plane pass and a wide high-plane pass, is fed byte by byte;
// a directed opening is followed by random runs, deliberate overflow and
// trailing bytes, and every fill request is checked against a typed table entry
// or against a behavioral decoder kept inside the bench
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tprle_pkg::*;

  localparam int unsigned PLANE_ENTRIES = 8192;
  // longest stretch with no handshake before the run is called hung
  localparam int unsigned STALL_LIMIT   = 2000;
  // long consumer hold-off used to back the decoder up into its input
  localparam int unsigned HOLD_CYCLES   = 300;
  // quiet cycles after the last expected request
  localparam int unsigned TAIL_CYCLES   = 20;
  // random pass bodies stop adding runs past this many elements
  localparam int unsigned BODY_ELEMS    = 6000;

  // one fill request as it leaves the decoder
  typedef struct packed {
    logic               plane;
    logic [START_W-1:0] start_pos;
    logic [COUNT_W-1:0] run_count;
    logic [BYTE_W-1:0]  fill_value;
    logic               last;
    logic               overflow;
  } fill_req_t;

  // how the outcome of a stimulus byte is known
  typedef enum logic [1:0] {
    CHK_PREDICT,  // worked out by the decoder model
    CHK_NONE,     // byte must give no request
    CHK_TYPED     // request written into the table
  } row_check_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    row_check_t        chk;
    fill_req_t         want;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // clock and block ports
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_plane;
  logic [START_W-1:0] out_start_pos;
  logic [COUNT_W-1:0] out_run_count;
  logic [BYTE_W-1:0]  out_fill_value;
  logic              out_last;
  logic              out_overflow;

  // check mode and typed request travel with the byte on the input port
  row_check_t row_mode = CHK_PREDICT;
  fill_req_t  row_want = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_plane_rle_decoder_core #(
    .PLANE_ENTRIES (PLANE_ENTRIES)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_plane      (out_plane),
    .out_start_pos  (out_start_pos),
    .out_run_count  (out_run_count),
    .out_fill_value (out_fill_value),
    .out_last       (out_last),
    .out_overflow   (out_overflow)
  );

  // ---------------------------------------------------------------------------
  // decoder model: state starts at its reset values, reset is applied once
  // ---------------------------------------------------------------------------
  phase_t             dec_phase    = PH_WIDTH;
  logic               dec_upper    = 1'b0;   // plane of the current pass
  logic               dec_wide     = 1'b0;   // two-byte headers
  logic [7:0]         dec_hdr_hi   = '0;
  logic [COUNT_W-1:0] dec_run_left = '0;
  int unsigned        dec_pos      = 0;      // saturates at PLANE_ENTRIES
  logic               dec_overflow = 1'b0;   // sticky

  fill_req_t   pending_fills[$];   // requests still owed by the decoder
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned idle_pct = 0;       // chance the sender skips a cycle
  int unsigned stall_pct = 0;      // chance the consumer stalls a cycle
  bit          hold_pending = 1'b0;
  int unsigned quiet_cycles = 0;

  // place a run at the current position, clipped to the plane
  function automatic bit place_run(input int unsigned count, input logic [7:0] value,
                                   output fill_req_t req);
    req = '0;
    if (count == 0) return 1'b0;
    if (dec_pos >= PLANE_ENTRIES) begin
      // nothing left below capacity: no request, flag still set
      dec_overflow = 1'b1;
      dec_pos = PLANE_ENTRIES;
      return 1'b0;
    end
    if (count > PLANE_ENTRIES - dec_pos) begin
      dec_overflow = 1'b1;
      count = PLANE_ENTRIES - dec_pos;
    end
    req.plane      = dec_upper;
    req.start_pos  = START_W'(dec_pos);
    req.run_count  = COUNT_W'(count);
    req.fill_value = value;
    req.last       = 1'b0;
    req.overflow   = dec_overflow;
    dec_pos += count;
    return 1'b1;
  endfunction

  // advance the model by one stream byte; returns 1 when a request results
  function automatic bit next_fill_request(input logic [7:0] b, output fill_req_t req);
    logic [15:0] hdr;
    bit          made;
    made = 1'b0;
    req = '0;
    case (dec_phase)
      PH_WIDTH: begin
        dec_wide = (b != NARROW_WIDTH_CODE);
        dec_pos = 0;
        dec_phase = dec_wide ? PH_HDR_HI : PH_HDR_LO;
      end
      PH_HDR_HI: begin
        dec_hdr_hi = b;
        dec_phase = PH_HDR_LO;
      end
      PH_HDR_LO: begin
        hdr = dec_wide ? {dec_hdr_hi, b} : {8'h00, b};
        if (hdr == '0) begin
          // end of pass marker, last only after the high plane
          req.plane = dec_upper;
          req.last = dec_upper;
          req.overflow = dec_overflow;
          made = 1'b1;
          dec_pos = 0;
          dec_run_left = '0;
          if (dec_upper) begin
            dec_phase = PH_DONE;
          end else begin
            dec_upper = 1'b1;
            dec_phase = PH_WIDTH;
          end
        end else if (dec_wide) begin
          dec_run_left = COUNT_W'(hdr & HDR16_COUNT);
          dec_phase = ((hdr & HDR16_REPEAT) != '0) ? PH_FILL : PH_LITERAL;
        end else begin
          dec_run_left = COUNT_W'(b & HDR8_COUNT);
          dec_phase = ((b & HDR8_REPEAT) != '0) ? PH_FILL : PH_LITERAL;
        end
      end
      PH_FILL: begin
        made = place_run(32'(dec_run_left), b, req);
        dec_run_left = '0;
        dec_phase = dec_wide ? PH_HDR_HI : PH_HDR_LO;
      end
      PH_LITERAL: begin
        made = place_run(1, b, req);
        if (dec_run_left != '0) dec_run_left = dec_run_left - COUNT_W'(1);
        if (dec_run_left == '0) dec_phase = dec_wide ? PH_HDR_HI : PH_HDR_LO;
      end
      default: ;  // stream finished, bytes are dropped
    endcase
    return made;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: input side first so a same-cycle request would still find its
  // expectation, then the output side against the oldest one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    fill_req_t pred;
    fill_req_t want;
    bit        has_pred;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        has_pred = next_fill_request(in_byte, pred);
        if (row_mode == CHK_TYPED) pending_fills.push_back(row_want);
        else if (row_mode == CHK_PREDICT && has_pred) pending_fills.push_back(pred);
      end
      if (out_valid && out_ready) begin
        if (pending_fills.size() == 0) begin
          $error("fill request with none expected: plane %0d start %0d count %0d",
                 out_plane, out_start_pos, out_run_count);
          mismatch_count++;
        end else begin
          want = pending_fills.pop_front();
          compare_field("plane", want.plane, out_plane);
          compare_field("start_pos", want.start_pos, out_start_pos);
          compare_field("run_count", want.run_count, out_run_count);
          compare_field("fill_value", want.fill_value, out_fill_value);
          compare_field("last", want.last, out_last);
          compare_field("overflow", want.overflow, out_overflow);
        end
      end
    end
  end

  // watchdog: any cycle without a handshake on either side counts
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // consumer: random stalls, or one long hold-off when asked for
  initial begin : consumer
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side: called at a falling edge, returns at the falling edge after
  // the request is taken, so back-to-back bytes keep valid high
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input row_check_t chk, input fill_req_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    row_mode <= chk;
    row_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    // traffic phases: free flow, idle sender, stalling consumer, both
    case ((items_sent / 270) % 5)
      1: begin idle_pct = 57; stall_pct = 0; end
      2: begin idle_pct = 0; stall_pct = 57; end
      3: begin idle_pct = 35; stall_pct = 35; end
      default: begin idle_pct = 0; stall_pct = 0; end
    endcase
  endtask

  task automatic send_random_byte();
    send_byte(8'($urandom), CHK_PREDICT, '0);
  endtask

  task automatic send_random_byte_fixed(input logic [7:0] b);
    send_byte(b, CHK_PREDICT, '0);
  endtask

  // run header, high byte first in the wide format
  task automatic send_header(input bit wide, input logic [15:0] hdr);
    if (wide) send_random_byte_fixed(hdr[15:8]);
    send_random_byte_fixed(hdr[7:0]);
  endtask

  // random runs of one pass, kept clear of the plane's end
  task automatic stream_pass_body(input bit wide, input int unsigned budget);
    int unsigned first;
    int unsigned elems;
    int unsigned pick;
    int unsigned count;
    first = items_sent;
    elems = 0;
    while (items_sent - first < budget && elems < BODY_ELEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // repeat run, now and then a long one
        if ($urandom_range(0, 19) == 0) count = wide ? $urandom_range(128, 700) : 127;
        else count = $urandom_range(0, 20);
        if (wide) send_header(1'b1, HDR16_REPEAT | 16'(count));
        else send_header(1'b0, {8'h00, HDR8_REPEAT | 8'(count)});
        send_random_byte();
      end else begin
        // literal run; a rare long one reaches the top of the one-byte count field
        if (pick < 98) count = $urandom_range(1, 6);
        else count = wide ? $urandom_range(128, 300) : 127;
        send_header(wide, 16'(count));
        repeat (count) send_random_byte();
      end
      elems += count;
    end
  endtask

  // push a pass past capacity: clipped run, runs with nothing left, end marker
  task automatic stream_pass_overflow(input bit wide);
    if (wide) begin
      send_header(1'b1, HDR16_REPEAT | HDR16_COUNT);
      send_random_byte();
      send_header(1'b1, HDR16_REPEAT | 16'd5);
      send_random_byte();
    end else begin
      repeat (66) begin
        send_header(1'b0, {8'h00, HDR8_REPEAT | HDR8_COUNT});
        send_random_byte();
      end
    end
    send_header(wide, 16'd2);
    repeat (2) send_random_byte();
    send_header(wide, 16'h0000);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_fills.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // directed opening of the low-plane pass, one-byte headers
  // ---------------------------------------------------------------------------
  stim_row_t opening_rows[22] = '{
    '{8'h01, CHK_NONE,    '0},                                        // narrow width byte
    '{8'h81, CHK_NONE,    '0},                                        // repeat 1
    '{8'h00, CHK_TYPED,   '{1'b0, 13'd0, 15'd1, 8'h00, 1'b0, 1'b0}},  // zero fill
    '{8'hFF, CHK_NONE,    '0},                                        // repeat 127
    '{8'hFF, CHK_TYPED,   '{1'b0, 13'd1, 15'd127, 8'hFF, 1'b0, 1'b0}},
    '{8'h80, CHK_NONE,    '0},                                        // repeat of zero
    '{8'h5A, CHK_NONE,    '0},                                        // fill swallowed
    '{8'h02, CHK_NONE,    '0},                                        // literal 2
    '{8'h00, CHK_TYPED,   '{1'b0, 13'd128, 15'd1, 8'h00, 1'b0, 1'b0}},
    '{8'hFF, CHK_TYPED,   '{1'b0, 13'd129, 15'd1, 8'hFF, 1'b0, 1'b0}},
    '{8'h01, CHK_NONE,    '0},                                        // literal 1
    '{8'hA5, CHK_PREDICT, '0},
    '{8'h83, CHK_NONE,    '0},                                        // repeat 3
    '{8'h3C, CHK_PREDICT, '0},
    '{8'h01, CHK_NONE,    '0},
    '{8'h80, CHK_PREDICT, '0},                                        // header-like literal
    '{8'h03, CHK_NONE,    '0},
    '{8'h00, CHK_PREDICT, '0},                                        // zero literal, not an end
    '{8'h81, CHK_PREDICT, '0},
    '{8'h01, CHK_PREDICT, '0},
    '{8'h8F, CHK_NONE,    '0},                                        // repeat 15
    '{8'h01, CHK_PREDICT, '0}
  };

  initial begin : stimulus
    logic [7:0] width_code;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening_rows[i]) begin
      send_byte(opening_rows[i].data, opening_rows[i].chk, opening_rows[i].want);
    end

    // low plane: random runs, then overflow and the end marker
    stream_pass_body(1'b0, 600);
    stream_pass_overflow(1'b0);

    // sender stops until the decoder has delivered everything
    wait_for_drain();

    // high plane with two-byte headers; any width code but the narrow one
    do width_code = 8'($urandom); while (width_code == NARROW_WIDTH_CODE);
    send_random_byte_fixed(width_code);
    // consumer holds off while bytes keep coming, so the input backs up
    hold_pending = 1'b1;
    stream_pass_body(1'b1, 580);
    stream_pass_overflow(1'b1);

    // bytes after the stream are dropped
    repeat (8) send_random_byte();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_fills.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
